>>> sv/tph_pkg.sv
`default_nettype none
package tph_pkg;

    localparam logic [2:0] PH_INIT    = 3'd0;
    localparam logic [2:0] PH_A       = 3'd1;
    localparam logic [2:0] PH_B       = 3'd2;
    localparam logic [2:0] PH_LEAVE_A = 3'd3;
    localparam logic [2:0] PH_LEAVE_B = 3'd4;

    localparam logic [2:0] REG_A_MAX     = 3'd0;
    localparam logic [2:0] REG_B_MIN     = 3'd1;
    localparam logic [2:0] REG_BIN_LO    = 3'd2;
    localparam logic [2:0] REG_BIN_SCALE = 3'd3;
    localparam logic [2:0] REG_BINS_USED = 3'd4;

    // Memory work that one sample calls for, or the clear after reset.
    typedef enum logic [2:0] {
        OP_NONE     = 3'd0,
        OP_EQ_BIN   = 3'd1,
        OP_CAND_BIN = 3'd2,
        OP_START    = 3'd3,
        OP_SETTLE   = 3'd4,
        OP_CROSS    = 3'd5,
        OP_CLEAR    = 3'd6
    } t_op;

endpackage
`default_nettype wire

>>> sv/tph_ram.sv
`default_nettype none
module tph_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                          i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

>>> sv/transition_path_histogram.sv
`default_nettype none
// Transition path histogram. Each sample word (kind 0) updates the phase
// tracker and the equilibrium, candidate and path histograms, which live in
// three single-port-read RAMs of MAX_BINS counts; a read word (kind 1) only
// reports. Every word returns one result word with the phase, the path just
// finished and the counts of bin i_bin_index after the word. A read word goes
// through the calc, read and response states; a sample also passes the multiply
// and decision states and, if it bins into the equilibrium or candidate
// histogram, a read-modify-write of that bin. A sample that starts, abandons or
// completes a path sweeps all MAX_BINS entries through a read-modify-write
// pipeline. No word is accepted while the RAMs are cleared after reset.
// Configuration registers sit at byte address 8*i; the user must write them
// only while the block is idle, and the block itself does not enforce this.
module transition_path_histogram #(
    parameter int MAX_BINS    = 1024,
    parameter int COUNT_WIDTH = 32,
    parameter int COORD_WIDTH = 48
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [5:0]                    paddr,
    input  wire logic [63:0]                   pwdata,
    output logic      [63:0]                   prdata,
    output logic                               pready,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic                          i_kind,
    input  wire logic signed [COORD_WIDTH-1:0] i_eq_coord,
    input  wire logic signed [COORD_WIDTH-1:0] i_tp_coord,
    input  wire logic [9:0]                    i_bin_index,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic      [2:0]                    o_phase,
    output logic                               o_path_done,
    output logic      [31:0]                   o_finished_path_length,
    output logic      [31:0]                   o_bin_eq_count,
    output logic      [31:0]                   o_bin_path_count,
    output logic      [31:0]                   o_total_eq_length,
    output logic      [31:0]                   o_total_path_length,
    output logic      [31:0]                   o_number_of_paths
);
    import tph_pkg::*;

    localparam int AW = MAX_BINS > 1 ? $clog2(MAX_BINS) : 1;
    localparam int CW = COUNT_WIDTH;
    localparam int XW = COORD_WIDTH;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_CALC   = 9'b000000010,
        S_MUL    = 9'b000000100,
        S_DEC    = 9'b000001000,
        S_RMW_RD = 9'b000010000,
        S_RMW_WR = 9'b000100000,
        S_SWEEP  = 9'b001000000,
        S_READ   = 9'b010000000,
        S_RESP   = 9'b100000000
    } t_state;

    function automatic logic [CW-1:0] f_sat(input logic [CW-1:0] a, input logic [CW-1:0] b,
                                            input logic c);
        logic [CW+1:0] s;
        s = (CW+2)'(a) + (CW+2)'(b) + (CW+2)'(c);
        return (s[CW+1:CW] != 2'b00) ? {CW{1'b1}} : s[CW-1:0];
    endfunction

    // Configuration.
    logic signed [XW-1:0] r_a_max, r_b_min, r_bin_lo;
    logic [31:0]          r_bin_scale;
    logic [10:0]          r_bins_used;
    logic [2:0]           cfg_idx;

    assign cfg_idx = paddr[5:3];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_max     <= XW'(64'sd32768);
            r_b_min     <= XW'(64'sd52429);
            r_bin_lo    <= XW'(-64'sd3276800000);
            r_bin_scale <= 32'd65536;
            r_bins_used <= 11'd20;
        end else if (psel && penable && pwrite) begin
            case (cfg_idx)
                REG_A_MAX:     r_a_max     <= pwdata[XW-1:0];
                REG_B_MIN:     r_b_min     <= pwdata[XW-1:0];
                REG_BIN_LO:    r_bin_lo    <= pwdata[XW-1:0];
                REG_BIN_SCALE: r_bin_scale <= pwdata[31:0];
                REG_BINS_USED: r_bins_used <= pwdata[10:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_A_MAX:     prdata = 64'(r_a_max);
            REG_B_MIN:     prdata = 64'(r_b_min);
            REG_BIN_LO:    prdata = 64'(r_bin_lo);
            REG_BIN_SCALE: prdata = 64'(r_bin_scale);
            REG_BINS_USED: prdata = 64'(r_bins_used);
            default:       prdata = 64'd0;
        endcase
    end

    // Control and working registers.
    t_state               r_state;
    t_op                  r_op, n_op;
    logic [2:0]           r_mode, n_mode;
    logic [CW-1:0]        r_clen, n_clen, r_eqlen, n_eqlen, r_plen, n_plen, r_pcnt, n_pcnt;
    logic                 r_done, n_done;
    logic [CW-1:0]        r_flen, n_flen;
    logic                 r_kind;
    logic signed [XW-1:0] r_eq, r_tp;
    logic [9:0]           r_bi;
    logic                 r_lt_a, r_gt_a, r_lt_b, r_gt_b, r_below;
    logic [63:0]          r_d, r_phi, r_plo;
    logic [AW-1:0]        r_bidx;
    logic                 r_bvalid;
    logic [AW:0]          r_cnt;
    logic                 r_wv;
    logic [AW-1:0]        r_wa;
    logic                 r_ovalid;

    logic signed [XW:0]   diff;
    logic [16:0]          nb;
    logic [33:0]          idx_sum;
    logic                 n_bvalid;
    logic [AW-1:0]        n_bidx;

    assign diff = $signed({r_tp[XW-1], r_tp}) - $signed({r_bin_lo[XW-1], r_bin_lo});
    assign nb   = (17'(r_bins_used) < 17'(MAX_BINS)) ? 17'(r_bins_used) : 17'(MAX_BINS);
    assign idx_sum = 34'(r_phi[16:0]) + 34'(r_plo[63:32]);

    always_comb begin
        if (r_below) begin
            n_bvalid = (r_bin_scale == 32'd0) && (nb != 17'd0);
            n_bidx   = '0;
        end else begin
            n_bvalid = (r_phi < 64'(nb)) && (idx_sum < 34'(nb));
            n_bidx   = AW'(idx_sum);
        end
    end

    // Phase decision for a sample.
    always_comb begin
        n_op    = OP_NONE;
        n_mode  = r_mode;
        n_clen  = r_clen;
        n_eqlen = r_eqlen;
        n_plen  = r_plen;
        n_pcnt  = r_pcnt;
        n_done  = 1'b0;
        n_flen  = '0;
        case (r_mode)
            PH_A: begin
                if (r_gt_a) begin
                    n_op = OP_START; n_mode = PH_LEAVE_A; n_clen = CW'(1);
                end else begin
                    n_op = OP_EQ_BIN; n_eqlen = f_sat(r_eqlen, '0, 1'b1);
                end
            end
            PH_B: begin
                if (r_lt_b) begin
                    n_op = OP_START; n_mode = PH_LEAVE_B; n_clen = CW'(1);
                end else begin
                    n_op = OP_EQ_BIN; n_eqlen = f_sat(r_eqlen, '0, 1'b1);
                end
            end
            PH_LEAVE_A, PH_LEAVE_B: begin
                if ((r_mode == PH_LEAVE_A) ? r_lt_a : r_gt_b) begin
                    n_op    = OP_SETTLE;
                    n_mode  = (r_mode == PH_LEAVE_A) ? PH_A : PH_B;
                    n_eqlen = f_sat(r_eqlen, f_sat(r_clen, '0, 1'b1), 1'b0);
                end else if ((r_mode == PH_LEAVE_A) ? r_gt_b : r_lt_a) begin
                    n_op    = OP_CROSS;
                    n_mode  = (r_mode == PH_LEAVE_A) ? PH_B : PH_A;
                    n_plen  = f_sat(r_plen, r_clen, 1'b0);
                    n_pcnt  = f_sat(r_pcnt, '0, 1'b1);
                    n_done  = 1'b1;
                    n_flen  = r_clen;
                    n_eqlen = f_sat(r_eqlen, f_sat(r_clen, '0, 1'b1), 1'b0);
                end else begin
                    n_op   = OP_CAND_BIN;
                    n_clen = f_sat(r_clen, '0, 1'b1);
                end
            end
            default: begin
                if (r_lt_a || r_gt_b) begin
                    n_op    = OP_EQ_BIN;
                    n_mode  = r_lt_a ? PH_A : PH_B;
                    n_eqlen = f_sat(r_eqlen, '0, 1'b1);
                end
            end
        endcase
    end

    // Memory ports.
    logic [AW-1:0] raddr, waddr;
    logic          we_eq, we_path, we_cand;
    logic [CW-1:0] wd_eq, wd_path, wd_cand;
    logic [CW-1:0] rd_eq, rd_path, rd_cand;
    logic          hit;

    assign hit = r_bvalid && (r_wa == r_bidx);

    always_comb begin
        raddr   = AW'(r_bi);
        waddr   = r_bidx;
        we_eq   = 1'b0;
        we_path = 1'b0;
        we_cand = 1'b0;
        wd_eq   = f_sat(rd_eq, rd_cand, hit);
        wd_path = f_sat(rd_path, rd_cand, 1'b0);
        wd_cand = f_sat(rd_cand, '0, 1'b1);
        case (r_state)
            S_RMW_RD: raddr = r_bidx;
            S_RMW_WR: begin
                raddr   = r_bidx;
                wd_eq   = f_sat(rd_eq, '0, 1'b1);
                we_eq   = (r_op == OP_EQ_BIN);
                we_cand = (r_op == OP_CAND_BIN);
            end
            S_SWEEP: begin
                raddr = r_cnt[AW-1:0];
                waddr = r_wa;
                case (r_op)
                    OP_CLEAR: begin
                        wd_eq = '0; wd_path = '0; wd_cand = '0;
                        we_eq = r_wv; we_path = r_wv; we_cand = r_wv;
                    end
                    OP_START: begin
                        wd_cand = CW'(hit);
                        we_cand = r_wv;
                    end
                    OP_SETTLE: we_eq = r_wv;
                    OP_CROSS: begin
                        we_eq   = r_wv;
                        we_path = r_wv;
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    tph_ram #(.WIDTH(CW), .DEPTH(MAX_BINS)) u_eq_ram (
        .i_clk(i_clk), .i_we(we_eq), .i_waddr(waddr), .i_wdata(wd_eq),
        .i_raddr(raddr), .o_rdata(rd_eq)
    );
    tph_ram #(.WIDTH(CW), .DEPTH(MAX_BINS)) u_path_ram (
        .i_clk(i_clk), .i_we(we_path), .i_waddr(waddr), .i_wdata(wd_path),
        .i_raddr(raddr), .o_rdata(rd_path)
    );
    tph_ram #(.WIDTH(CW), .DEPTH(MAX_BINS)) u_cand_ram (
        .i_clk(i_clk), .i_we(we_cand), .i_waddr(waddr), .i_wdata(wd_cand),
        .i_raddr(raddr), .o_rdata(rd_cand)
    );

    logic bi_ok, load;

    assign bi_ok   = 32'(r_bi) < 32'(MAX_BINS);
    assign load    = (r_state == S_RESP) && (!r_ovalid || !i_stall);
    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ovalid;

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_SWEEP;
            r_op     <= OP_CLEAR;
            r_cnt    <= '0;
            r_wv     <= 1'b0;
            r_mode   <= PH_INIT;
            r_clen   <= '0;
            r_eqlen  <= '0;
            r_plen   <= '0;
            r_pcnt   <= '0;
            r_ovalid <= 1'b0;
            r_bvalid <= 1'b0;
        end else begin
            if (load) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_state <= S_CALC;
                    end
                end
                S_CALC: begin
                    r_state <= r_kind ? S_READ : S_MUL;
                end
                S_MUL: r_state <= S_DEC;
                S_DEC: begin
                    r_op     <= n_op;
                    r_mode   <= n_mode;
                    r_clen   <= n_clen;
                    r_eqlen  <= n_eqlen;
                    r_plen   <= n_plen;
                    r_pcnt   <= n_pcnt;
                    r_bvalid <= n_bvalid;
                    r_cnt    <= '0;
                    r_wv     <= 1'b0;
                    if (n_op == OP_START || n_op == OP_SETTLE || n_op == OP_CROSS) begin
                        r_state <= S_SWEEP;
                    end else if ((n_op == OP_EQ_BIN || n_op == OP_CAND_BIN) && n_bvalid) begin
                        r_state <= S_RMW_RD;
                    end else begin
                        r_state <= S_READ;
                    end
                end
                S_RMW_RD: r_state <= S_RMW_WR;
                S_RMW_WR: r_state <= S_READ;
                S_SWEEP: begin
                    // Read of entry r_cnt overlaps the write-back of the one before it.
                    if (r_cnt != (AW+1)'(MAX_BINS)) begin
                        r_cnt <= r_cnt + 1'b1;
                        r_wv  <= 1'b1;
                    end else begin
                        r_wv <= 1'b0;
                        if (r_wv) begin
                            r_state <= (r_op == OP_CLEAR) ? S_IDLE : S_READ;
                        end
                    end
                end
                S_READ: r_state <= S_RESP;
                S_RESP: begin
                    if (load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_kind <= i_kind;
            r_eq   <= i_eq_coord;
            r_tp   <= i_tp_coord;
            r_bi   <= i_bin_index;
        end
        if (r_state == S_CALC) begin
            r_lt_a  <= r_eq < r_a_max;
            r_gt_a  <= r_eq > r_a_max;
            r_lt_b  <= r_eq < r_b_min;
            r_gt_b  <= r_eq > r_b_min;
            r_below <= r_tp < r_bin_lo;
            r_d     <= 64'(diff[XW-1:0]);
            r_done  <= 1'b0;
            r_flen  <= '0;
        end
        if (r_state == S_MUL) begin
            r_phi <= 64'(r_d[63:32]) * 64'(r_bin_scale);
            r_plo <= 64'(r_d[31:0]) * 64'(r_bin_scale);
        end
        if (r_state == S_DEC) begin
            r_bidx <= n_bidx;
            r_done <= n_done;
            r_flen <= n_flen;
        end
        if (r_state == S_SWEEP) begin
            r_wa <= r_cnt[AW-1:0];
        end
        if (load) begin
            o_phase                <= r_mode;
            o_path_done            <= r_done;
            o_finished_path_length <= 32'(r_flen);
            o_bin_eq_count         <= bi_ok ? 32'(rd_eq) : 32'd0;
            o_bin_path_count       <= bi_ok ? 32'(rd_path) : 32'd0;
            o_total_eq_length      <= 32'(r_eqlen);
            o_total_path_length    <= 32'(r_plen);
            o_number_of_paths      <= 32'(r_pcnt);
        end
    end

endmodule
`default_nettype wire
